// ===== rtl/vfd_pkg.sv =====
// shared types, constants and helpers for the video frame deframer
`default_nettype none

package vfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned REM_W = 34;

  localparam logic [23:0] SYNC_PREFIX = 24'hFFFFAA;
  localparam logic [7:0]  SYNC_TAIL   = 8'h55;
  localparam logic [15:0] HDR_BYTES   = 16'd16;

  // one payload byte with the header fields of its frame
  typedef struct packed {
    logic        missed_frame;
    logic [5:0]  pixel_depth;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [15:0] frame_number;
    logic        frame_last;
    logic        frame_first;
    logic [7:0]  pixel_byte;
  } vfd_item_t;

  // depth code 8 -> 1 byte, 9..16 -> 2 bytes, 17..32 -> 4 bytes
  function automatic logic depth_ok(logic [15:0] depth);
    return (depth >= 16'd8) && (depth <= 16'd32);
  endfunction

  function automatic logic [1:0] depth_shift(logic [15:0] depth);
    logic [1:0] sh;
    if (depth == 16'd8) begin
      sh = 2'd0;
    end else if (depth <= 16'd16) begin
      sh = 2'd1;
    end else begin
      sh = 2'd2;
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vfd_front.sv =====
// front end: sync hunt, header parse, skip and payload tagging
`default_nettype none

module vfd_front import vfd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_data_i,
  output logic                 item_valid_o,
  output vfd_item_t            item_o,
  input  wire logic            item_ready_i
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_SKIP,
    PH_PAYLOAD
  } phase_e;

  localparam logic [3:0] OFF_AFTER_SYNC = 4'd4;
  localparam logic [3:0] OFF_HLEN_LO    = 4'd6;
  localparam logic [3:0] OFF_HLEN_HI    = 4'd7;
  localparam logic [3:0] OFF_NUM_LO     = 4'd8;
  localparam logic [3:0] OFF_NUM_HI     = 4'd9;
  localparam logic [3:0] OFF_WID_LO     = 4'd10;
  localparam logic [3:0] OFF_WID_HI     = 4'd11;
  localparam logic [3:0] OFF_HGT_LO     = 4'd12;
  localparam logic [3:0] OFF_HGT_HI     = 4'd13;
  localparam logic [3:0] OFF_DEP_LO     = 4'd14;
  localparam logic [3:0] OFF_DEP_HI     = 4'd15;

  phase_e            phase_q, phase_d;
  logic [23:0]       sync_q, sync_d;
  logic [3:0]        off_q, off_d;
  logic [15:0]       hlen_q, hlen_d;
  logic [15:0]       num_q, num_d;
  logic [15:0]       wid_q, wid_d;
  logic [15:0]       hgt_q, hgt_d;
  logic [15:0]       dep_q, dep_d;
  logic [15:0]       skip_q, skip_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [15:0]       prev_q, prev_d;
  logic              gap_q, gap_d;
  logic              first_q, first_d;
  logic [31:0]       wh_q, wh_d;

  logic              accept;
  logic              is_last;
  logic [15:0]       dep_full;
  logic [REM_W-1:0]  size;
  logic [15:0]       hlen_eff;

  assign in_ready_o   = item_ready_i;
  assign accept       = in_valid_i && item_ready_i;
  assign is_last      = (rem_q[REM_W-1:1] == '0);
  assign item_valid_o = accept && (phase_q == PH_PAYLOAD);

  // depth high byte arrives with the last header byte
  assign dep_full = {in_data_i, dep_q[7:0]};
  assign size     = REM_W'(wh_q) << depth_shift(dep_full);
  assign hlen_eff = (hlen_q < HDR_BYTES) ? HDR_BYTES : hlen_q;

  always_comb begin
    item_o.pixel_byte   = in_data_i;
    item_o.frame_first  = first_q;
    item_o.frame_last   = is_last;
    item_o.frame_number = num_q;
    item_o.frame_width  = wid_q;
    item_o.frame_height = hgt_q;
    item_o.pixel_depth  = dep_q[5:0];
    item_o.missed_frame = gap_q;
  end

  always_comb begin
    phase_d = phase_q;
    sync_d  = sync_q;
    off_d   = off_q;
    hlen_d  = hlen_q;
    num_d   = num_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    dep_d   = dep_q;
    skip_d  = skip_q;
    rem_d   = rem_q;
    prev_d  = prev_q;
    gap_d   = gap_q;
    first_d = first_q;
    wh_d    = wh_q;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (sync_q == SYNC_PREFIX && in_data_i == SYNC_TAIL) begin
            phase_d = PH_HEADER;
            off_d   = OFF_AFTER_SYNC;
            sync_d  = '0;
          end else begin
            sync_d = {sync_q[15:0], in_data_i};
          end
        end
        PH_HEADER: begin
          unique case (off_q)
            OFF_HLEN_LO: hlen_d[7:0]  = in_data_i;
            OFF_HLEN_HI: hlen_d[15:8] = in_data_i;
            OFF_NUM_LO:  num_d[7:0]   = in_data_i;
            OFF_NUM_HI:  num_d[15:8]  = in_data_i;
            OFF_WID_LO:  wid_d[7:0]   = in_data_i;
            OFF_WID_HI:  wid_d[15:8]  = in_data_i;
            OFF_HGT_LO:  hgt_d[7:0]   = in_data_i;
            OFF_HGT_HI:  hgt_d[15:8]  = in_data_i;
            OFF_DEP_LO: begin
              dep_d[7:0] = in_data_i;
              // width and height are complete here
              wh_d = {16'b0, wid_q} * {16'b0, hgt_q};
            end
            OFF_DEP_HI:  dep_d[15:8]  = in_data_i;
            default: ;
          endcase
          if (off_q == OFF_DEP_HI) begin
            off_d = '0;
            if (!depth_ok(dep_full) || wh_q == '0) begin
              phase_d = PH_HUNT;
              sync_d  = '0;
            end else begin
              rem_d   = size;
              first_d = 1'b1;
              gap_d   = (num_q != prev_q + 16'd1) && (num_q != prev_q);
              skip_d  = hlen_eff - HDR_BYTES;
              phase_d = (hlen_eff != HDR_BYTES) ? PH_SKIP : PH_PAYLOAD;
            end
          end else begin
            off_d = off_q + 4'd1;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 16'd1;
          if (skip_d == '0) begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          first_d = 1'b0;
          if (is_last) begin
            rem_d   = '0;
            prev_d  = num_q;
            phase_d = PH_HUNT;
            sync_d  = '0;
          end else begin
            rem_d = rem_q - REM_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sync_q  <= '0;
      off_q   <= '0;
      hlen_q  <= '0;
      num_q   <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      dep_q   <= '0;
      skip_q  <= '0;
      rem_q   <= '0;
      prev_q  <= '0;
      gap_q   <= 1'b0;
      first_q <= 1'b0;
      wh_q    <= '0;
    end else begin
      phase_q <= phase_d;
      sync_q  <= sync_d;
      off_q   <= off_d;
      hlen_q  <= hlen_d;
      num_q   <= num_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      dep_q   <= dep_d;
      skip_q  <= skip_d;
      rem_q   <= rem_d;
      prev_q  <= prev_d;
      gap_q   <= gap_d;
      first_q <= first_d;
      wh_q    <= wh_d;
    end
  end

  a_last_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_o && is_last) |=> (phase_q == PH_HUNT && sync_q == '0))
    else $error("frame end did not restart the sync hunt");

  a_payload_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != '0))
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

// ===== rtl/vfd_queue.sv =====
// short item queue between the parser and the output stage
`default_nettype none

module vfd_queue import vfd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire vfd_item_t  push_item_i,
  output logic            ready_o,
  output logic            valid_o,
  output vfd_item_t       item_o,
  input  wire logic       pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  vfd_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CNT_FULL))
    else $error("request pushed into a full queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue fill count out of step with pushes");

endmodule

`default_nettype wire

// ===== rtl/vfd_out_stage.sv =====
// output register: drains the queue onto the master stream
`default_nettype none

module vfd_out_stage import vfd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  input  wire vfd_item_t              item_i,
  output logic                        item_pop_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  logic      valid_q;
  vfd_item_t item_q;

  // take a new request when the register is empty or being emptied
  assign item_pop_o = item_valid_i && (!valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tlast_o  = item_q.frame_last;
  assign m_axis_tdata_o  = {2'b00, item_q.pixel_depth, item_q.frame_height,
                            item_q.frame_width, item_q.frame_number, item_q.pixel_byte};
  assign m_axis_tuser_o  = {item_q.missed_frame, item_q.frame_first};

endmodule

`default_nettype wire

// ===== rtl/video_frame_deframer_unit.sv =====
// top level of the sync word video frame deframer
//
//  port group   dir  tdata                                    tuser          tlast
//  s_axis       in   data_byte[7:0]                           -              -
//  m_axis       out  pixel_byte, number, width, height, depth  first, missed  frame_last
//
//  one stream byte per cycle is taken in every phase (hunt, header, skip, payload)
//  each accepted payload byte passes through the item queue and the output register to m_axis
//  the parser runs at one byte per cycle; only a full item queue stops it
//  s_axis_tready_o falls when the queue is full while m_axis is stalled
//  reset clears the parser to sync hunt with previous frame number zero
`default_nettype none

module video_frame_deframer_unit import vfd_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [7:0] pixel_byte, [23:8] frame_number, [39:24] frame_width,
  // [55:40] frame_height, [61:56] pixel_depth, [63:62] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser_o,   // [0] frame_first, [1] missed_frame
  output logic                        m_axis_tlast_o    // frame_last
);

  logic      fr_valid;
  vfd_item_t fr_item;
  logic      q_ready;
  logic      q_valid;
  vfd_item_t q_item;
  logic      q_pop;

  vfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_ready_i (q_ready)
  );

  vfd_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid),
    .push_item_i (fr_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  vfd_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_i          (q_item),
    .item_pop_o      (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_video_frame_deframer_unit.sv =====
// self-checking testbench for the sync word video frame deframer
`default_nettype none

module tb_video_frame_deframer_unit;
  import vfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_BYTES = 40;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_SKIP,
    PH_PAYLOAD
  } parse_phase_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  logic [IN_TDATA_W-1:0]  byte_data = '0;
  logic                   pix_valid;
  logic                   pix_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] pix_data;
  logic [OUT_TUSER_W-1:0] pix_user;
  logic                   pix_last;

  // stream state tracked alongside the block
  parse_phase_e phase = PH_HUNT;
  logic [23:0]  sync_hist = '0;
  logic [3:0]   hdr_pos = '0;
  logic [15:0]  hdr_len = '0;
  logic [15:0]  cur_num = '0;
  logic [15:0]  cur_width = '0;
  logic [15:0]  cur_height = '0;
  logic [15:0]  cur_depth = '0;
  logic [15:0]  skip_left = '0;
  logic [33:0]  pay_left = '0;
  logic [15:0]  prev_num = '0;
  logic         gap_flag = 1'b0;

  vfd_item_t pending_pixels[$];

  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int unsigned sink_stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned bytes_sent = 0;
  logic [15:0] stim_num = '0;

  always #4 clk = ~clk;

  video_frame_deframer_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (byte_ready),
    .s_axis_tdata_i  (byte_data),
    .m_axis_tvalid_o (pix_valid),
    .m_axis_tready_i (pix_ready),
    .m_axis_tdata_o  (pix_data),
    .m_axis_tuser_o  (pix_user),
    .m_axis_tlast_o  (pix_last)
  );

  function automatic logic [2:0] depth_bytes(logic [15:0] depth);
    if (depth == 16'd8) return 3'd1;
    if (depth >= 16'd9 && depth <= 16'd16) return 3'd2;
    if (depth >= 16'd17 && depth <= 16'd32) return 3'd4;
    return 3'd0;
  endfunction

  function automatic logic [33:0] payload_size(logic [15:0] w, logic [15:0] h,
                                               logic [15:0] depth);
    return 34'(w) * 34'(h) * 34'(depth_bytes(depth));
  endfunction

  // advance the tracked stream state by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    vfd_item_t   px;
    logic [33:0] size;
    logic [15:0] hl;
    case (phase)
      PH_HUNT: begin
        if (sync_hist == SYNC_PREFIX && b == SYNC_TAIL) begin
          phase = PH_HEADER;
          hdr_pos = 4'd4;
          sync_hist = '0;
        end else begin
          sync_hist = {sync_hist[15:0], b};
        end
      end
      PH_HEADER: begin
        case (hdr_pos)
          4'd6:  hdr_len[7:0] = b;
          4'd7:  hdr_len[15:8] = b;
          4'd8:  cur_num[7:0] = b;
          4'd9:  cur_num[15:8] = b;
          4'd10: cur_width[7:0] = b;
          4'd11: cur_width[15:8] = b;
          4'd12: cur_height[7:0] = b;
          4'd13: cur_height[15:8] = b;
          4'd14: cur_depth[7:0] = b;
          4'd15: cur_depth[15:8] = b;
          default: ;
        endcase
        if (hdr_pos == 4'd15) begin
          hdr_pos = '0;
          size = payload_size(cur_width, cur_height, cur_depth);
          if (size == '0) begin
            phase = PH_HUNT;
            sync_hist = '0;
          end else begin
            pay_left = size;
            gap_flag = (cur_num != prev_num + 16'd1) && (cur_num != prev_num);
            hl = (hdr_len < HDR_BYTES) ? HDR_BYTES : hdr_len;
            skip_left = hl - HDR_BYTES;
            phase = (skip_left != '0) ? PH_SKIP : PH_PAYLOAD;
          end
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == '0) phase = PH_PAYLOAD;
      end
      default: begin
        size = payload_size(cur_width, cur_height, cur_depth);
        px.pixel_byte = b;
        px.frame_first = (pay_left == size);
        px.frame_last = (pay_left <= 34'd1);
        px.frame_number = cur_num;
        px.frame_width = cur_width;
        px.frame_height = cur_height;
        px.pixel_depth = cur_depth[5:0];
        px.missed_frame = gap_flag;
        pending_pixels = {pending_pixels, px};
        if (px.frame_first) frames_seen++;
        if (px.frame_last) begin
          pay_left = '0;
          prev_num = cur_num;
          phase = PH_HUNT;
          sync_hist = '0;
        end else begin
          pay_left = pay_left - 34'd1;
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= b;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      // lean toward sync bytes so partial sync words show up
      case ($urandom_range(0, 3))
        0: send_byte(8'hFF);
        1: send_byte(8'hAA);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // sync word, header, skipped bytes and payload; pay_len < 0 sends the full payload
  task automatic send_frame(input logic [15:0] num, input logic [15:0] w,
                            input logic [15:0] h, input logic [15:0] depth,
                            input logic [15:0] hlen, input int pay_len,
                            input bit sync_in_body);
    logic [7:0]  sync_word[4];
    logic [33:0] size;
    int          n;
    int          skip;
    sync_word = '{8'hFF, 8'hFF, 8'hAA, 8'h55};
    size = payload_size(w, h, depth);
    foreach (sync_word[i]) send_byte(sync_word[i]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(hlen[7:0]);
    send_byte(hlen[15:8]);
    send_byte(num[7:0]);
    send_byte(num[15:8]);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
    send_byte(h[7:0]);
    send_byte(h[15:8]);
    send_byte(depth[7:0]);
    send_byte(depth[15:8]);
    if (size == '0) return;
    skip = (hlen > HDR_BYTES) ? int'(hlen - HDR_BYTES) : 0;
    for (int i = 0; i < skip; i++) begin
      if (sync_in_body && i < 4) send_byte(sync_word[i]);
      else send_byte(8'($urandom));
    end
    n = (pay_len < 0) ? int'(size) : pay_len;
    for (int i = 0; i < n; i++) begin
      if (sync_in_body && i < 4) send_byte(sync_word[i]);
      else send_byte(8'($urandom));
    end
    stim_num = num;
  endtask

  function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_pixel();
    vfd_item_t want;
    int        bad;
    if (pending_pixels.size() == 0) begin
      $error("unexpected output: pixel_byte %0h with nothing pending", pix_data[7:0]);
      errors++;
      return;
    end
    want = pending_pixels.pop_front();
    bad = 0;
    bad += field_diff("pixel_byte", 16'(want.pixel_byte), 16'(pix_data[7:0]));
    bad += field_diff("frame_first", 16'(want.frame_first), 16'(pix_user[0]));
    bad += field_diff("frame_last", 16'(want.frame_last), 16'(pix_last));
    bad += field_diff("frame_number", want.frame_number, pix_data[23:8]);
    bad += field_diff("frame_width", want.frame_width, pix_data[39:24]);
    bad += field_diff("frame_height", want.frame_height, pix_data[55:40]);
    bad += field_diff("pixel_depth", 16'(want.pixel_depth), 16'(pix_data[61:56]));
    bad += field_diff("missed_frame", 16'(want.missed_frame), 16'(pix_user[1]));
    if (bad != 0) errors++;
    pixels_checked++;
  endtask

  // output side: check accepted pixels and apply random backpressure
  always @(posedge clk) begin
    if (rst_n && pix_valid && pix_ready) check_pixel();
    if (sink_stall_left != 0) begin
      pix_ready <= 1'b0;
      sink_stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      pix_ready <= 1'b0;
      sink_stall_left = $urandom_range(0, 4);
    end else begin
      pix_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
               pending_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // first frame compares against a previous number of zero
  task automatic test_first_frame_after_reset();
    send_frame(16'd1, 16'd1, 16'd1, 16'd8, 16'd16, -1, 1'b0);
    send_frame(16'd1, 16'd2, 16'd1, 16'd8, 16'd0, -1, 1'b0);
  endtask

  task automatic test_pixel_depths();
    send_frame(16'd2, 16'd1, 16'd1, 16'd9, 16'd16, -1, 1'b0);
    send_frame(16'd3, 16'd1, 16'd1, 16'd16, 16'd16, -1, 1'b0);
    send_frame(16'd4, 16'd1, 16'd1, 16'd17, 16'd16, -1, 1'b0);
    send_frame(16'd5, 16'd2, 16'd1, 16'd32, 16'd16, -1, 1'b0);
  endtask

  // bad depths and zero dimensions drop the header and restart the hunt
  task automatic test_dropped_headers();
    send_frame(16'd6, 16'd1, 16'd1, 16'd7, 16'd16, -1, 1'b0);
    send_frame(16'd6, 16'd1, 16'd1, 16'd33, 16'd16, -1, 1'b0);
    send_frame(16'd6, 16'd1, 16'd1, 16'h0108, 16'd16, -1, 1'b0);
    send_frame(16'd6, 16'd1, 16'd1, 16'd0, 16'd16, -1, 1'b0);
    send_frame(16'd6, 16'hFFFF, 16'd0, 16'd8, 16'd16, -1, 1'b0);
    send_frame(16'd6, 16'd0, 16'hFFFF, 16'd32, 16'hFFFF, -1, 1'b0);
    send_frame(16'd6, 16'd1, 16'd1, 16'd8, 16'd16, -1, 1'b0);
  endtask

  task automatic test_header_lengths();
    send_frame(16'd7, 16'd1, 16'd1, 16'd8, 16'd15, -1, 1'b0);
    send_frame(16'd8, 16'd1, 16'd1, 16'd8, 16'd17, -1, 1'b0);
    send_frame(16'd9, 16'd1, 16'd1, 16'd8, 16'd40, -1, 1'b1);
  endtask

  // same number, wrap to zero, and a jump
  task automatic test_frame_numbering();
    send_frame(16'hFFFF, 16'd1, 16'd1, 16'd8, 16'd16, -1, 1'b0);
    send_frame(16'h0000, 16'd1, 16'd1, 16'd8, 16'd16, -1, 1'b0);
    send_frame(16'h0000, 16'd1, 16'd1, 16'd8, 16'd16, -1, 1'b0);
    send_frame(16'h8000, 16'd1, 16'd1, 16'd8, 16'd16, -1, 1'b0);
  endtask

  task automatic test_sync_word_edges();
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h54);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h55);
    // extra leading sync byte still finds the word
    send_byte(8'hFF);
    send_frame(16'h8001, 16'd2, 16'd3, 16'd8, 16'd16, -1, 1'b1);
  endtask

  task automatic test_random_stream();
    int unsigned frame_bytes;
    logic [15:0] num;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] depth;
    logic [15:0] hlen;
    int          pay_len;
    frame_bytes = 0;
    while (frame_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0: send_noise($urandom_range(1, 8));
        1: begin
          // broken sync word or a frame cut short
          if ($urandom_range(0, 1) == 0) begin
            send_byte(8'hFF);
            send_byte(8'hFF);
            send_byte(8'($urandom));
          end else begin
            send_frame(16'($urandom), 16'd4, 16'd2, 16'd8, 16'd16,
                       $urandom_range(0, 6), 1'b0);
            send_noise($urandom_range(2, 10));
          end
        end
        default: begin
          case ($urandom_range(0, 9))
            0: num = stim_num;
            1: num = 16'($urandom);
            default: num = stim_num + 16'd1;
          endcase
          w = 16'($urandom_range(1, 4));
          h = 16'($urandom_range(1, 3));
          case ($urandom_range(0, 11))
            0: depth = 16'($urandom_range(0, 7));
            1: depth = 16'($urandom_range(33, 255));
            2: depth = 16'($urandom);
            3: w = '0;
            4: h = '0;
            5, 6: depth = 16'd8;
            7, 8: depth = 16'($urandom_range(9, 16));
            default: depth = 16'($urandom_range(17, 32));
          endcase
          case ($urandom_range(0, 3))
            0: hlen = 16'($urandom_range(0, 15));
            1: hlen = 16'($urandom_range(17, 22));
            2: hlen = {8'($urandom), 8'($urandom_range(0, 15))} & 16'h000F;
            default: hlen = HDR_BYTES;
          endcase
          pay_len = -1;
          send_frame(num, w, h, depth, hlen, pay_len, $urandom_range(0, 7) == 0);
          frame_bytes += 16 + int'(payload_size(w, h, depth));
          if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 3));
        end
      endcase
    end
  endtask

  // full rate on both sides to the end of the run
  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (3) begin
      send_frame(stim_num + 16'd1, 16'($urandom_range(1, 5)), 16'($urandom_range(1, 3)),
                 16'($urandom_range(8, 32)), 16'($urandom_range(0, 18)), -1, 1'b0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_frame_after_reset();
    test_pixel_depths();
    test_dropped_headers();
    test_header_lengths();
    test_frame_numbering();
    test_sync_word_edges();
    test_random_stream();
    test_back_to_back();
    byte_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d stream bytes in %0d cycles", bytes_sent, cycle_count);
    $display("checked %0d payload bytes over %0d frames, %0d bad", pixels_checked,
             frames_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/vfd_pkg.sv
rtl/vfd_front.sv
rtl/vfd_queue.sv
rtl/vfd_out_stage.sv
rtl/video_frame_deframer_unit.sv
tb/tb_video_frame_deframer_unit.sv
